### hw/rtl/hsl_to_rgb16_unit_assert.svh
// Assertion macros used by the RTL of the color converter.
`ifndef HSL_TO_RGB16_UNIT_ASSERT_SVH
`define HSL_TO_RGB16_UNIT_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define HSL_ASSERT_SAME(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define HSL_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

### hw/rtl/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

   localparam int INPUT_FRAC_BITS = 4;

   // full scale of saturation and lightness, one hue sector, full circle
   localparam int SAT_FULL = 100 << INPUT_FRAC_BITS;
   localparam int SECTOR   = 60 << INPUT_FRAC_BITS;
   localparam int HUE_FULL = 6 * SECTOR;

   // D*D*E = 600000 * 2^(3F) = 9375 * 2^(6 + 3F)
   localparam int DEN_ODD   = 9375;
   localparam int DEN_SHIFT = 6 + 3 * INPUT_FRAC_BITS;

   // reciprocal of the odd part, a slight underestimate
   localparam int RECIP_SHIFT = 44;
   localparam logic [30:0] RECIP = 31'((64'd1 << RECIP_SHIFT) / 64'(DEN_ODD));

   localparam int STAGES = 8;

   // lanes of the scaling datapath
   localparam int LANE_V = 0;
   localparam int LANE_M = 1;
   localparam int LANE_K = 2;
   localparam int LANE_N = 3;
   localparam int LANES  = 4;

   // hue sectors
   localparam logic [2:0] SECT_RY = 3'd0;
   localparam logic [2:0] SECT_YG = 3'd1;
   localparam logic [2:0] SECT_GC = 3'd2;
   localparam logic [2:0] SECT_CB = 3'd3;
   localparam logic [2:0] SECT_BM = 3'd4;
   localparam logic [2:0] SECT_MR = 3'd5;

   typedef struct packed {
      logic [12:0] hue;
      logic [10:0] saturation;
      logic [10:0] lightness;
   } hsl_req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } hsl_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/hsl_to_rgb16_unit.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  hsl_req_type: hue, saturation, lightness
// rsp       out        rsp_valid/rsp_ready  hsl_rsp_type: red, green, blue
//
// Eight register stages; one request enters per clock while rsp is not stalled,
// and its result is offered once it reaches the last stage.
// The last stage is the output register; the reciprocal multiply stage sets the depth.
// Reset (synchronous) clears the stage valid bits only; the data registers are not reset.
// A stall on rsp freezes every stage at once, so req_ready follows rsp_ready
// whenever the output register is occupied.
`default_nettype none
`include "hsl_to_rgb16_unit_assert.svh"

module hsl_to_rgb16_unit import hsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  hsl_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output hsl_rsp_type rsp_payload
);

   logic              adv;
   logic [STAGES-1:0] valid_ff, valid_in;

   // stage 1
   logic [12:0] hue_c;
   logic [10:0] sat_in, light_in;
   logic [2:0]  sect1_in, sect1_ff;
   logic [9:0]  frac1_in, frac1_ff;
   logic [10:0] sat1_ff, light1_ff;
   logic [21:0] lsq1_in, lsq1_ff;
   logic        low1_in, low1_ff;

   // stage 2
   logic [22:0] ld, sd, vsum;
   logic [21:0] vn2_in, vn2_ff, mn2_in, mn2_ff;
   logic [2:0]  sect2_ff;
   logic [9:0]  frac2_ff;

   // stage 3
   logic [21:0] diff;
   logic [31:0] p3_in, p3_ff, xv3_in, xv3_ff, xm3_in, xm3_ff;
   logic [2:0]  sect3_ff;

   // stage 4 to 8
   logic [LANES-1:0][31:0] x4_in, x4_ff;
   logic [LANES-1:0][47:0] w5;
   logic [LANES-1:0][29:0] y5_in, y5_ff, y6_ff, y7_ff;
   logic [LANES-1:0][60:0] prod6_in, prod6_ff;
   logic [LANES-1:0][16:0] q7_in, q7_ff;
   logic [LANES-1:0][29:0] t7_in, t7_ff;
   logic [LANES-1:0][29:0] r8;
   logic [LANES-1:0][15:0] q8;
   logic [2:0]  sect4_ff, sect5_ff, sect6_ff, sect7_ff;
   hsl_rsp_type rsp_in, rsp_ff;

   assign adv       = !valid_ff[STAGES-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_payload = rsp_ff;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: clamp, split hue into sector and fraction, l*s
   always_comb begin
      hue_c    = (req_payload.hue >= 13'(HUE_FULL)) ? 13'd0 : req_payload.hue;
      sat_in   = (req_payload.saturation > 11'(SAT_FULL)) ? 11'(SAT_FULL)
                                                          : req_payload.saturation;
      light_in = (req_payload.lightness > 11'(SAT_FULL)) ? 11'(SAT_FULL)
                                                         : req_payload.lightness;
      if (hue_c >= 13'(5 * SECTOR)) begin
         sect1_in = SECT_MR;
         frac1_in = 10'(hue_c - 13'(5 * SECTOR));
      end else if (hue_c >= 13'(4 * SECTOR)) begin
         sect1_in = SECT_BM;
         frac1_in = 10'(hue_c - 13'(4 * SECTOR));
      end else if (hue_c >= 13'(3 * SECTOR)) begin
         sect1_in = SECT_CB;
         frac1_in = 10'(hue_c - 13'(3 * SECTOR));
      end else if (hue_c >= 13'(2 * SECTOR)) begin
         sect1_in = SECT_GC;
         frac1_in = 10'(hue_c - 13'(2 * SECTOR));
      end else if (hue_c >= 13'(SECTOR)) begin
         sect1_in = SECT_YG;
         frac1_in = 10'(hue_c - 13'(SECTOR));
      end else begin
         sect1_in = SECT_RY;
         frac1_in = 10'(hue_c);
      end
      lsq1_in = 22'(light_in) * 22'(sat_in);
      low1_in = {light_in, 1'b0} <= 12'(SAT_FULL);
   end

   // stage 2: v and M as numerators over D*D
   always_comb begin
      ld     = 23'(light1_ff) * 23'(SAT_FULL);
      sd     = 23'(sat1_ff) * 23'(SAT_FULL);
      vsum   = low1_ff ? (ld + 23'(lsq1_ff)) : (ld + sd - 23'(lsq1_ff));
      vn2_in = 22'(vsum);
      mn2_in = 22'({ld, 1'b0} - {1'b0, vsum});
   end

   // stage 3: fraction times (v - M), rescale to D*D*E
   always_comb begin
      diff   = vn2_ff - mn2_ff;
      p3_in  = 32'(frac2_ff) * 32'(diff);
      xv3_in = 32'(vn2_ff) * 32'(SECTOR);
      xm3_in = 32'(mn2_ff) * 32'(SECTOR);
   end

   // stage 4: all four numerators
   always_comb begin
      x4_in[LANE_V] = xv3_ff;
      x4_in[LANE_M] = xm3_ff;
      x4_in[LANE_K] = xm3_ff + p3_ff;
      x4_in[LANE_N] = xv3_ff - p3_ff;
   end

   // stage 5 to 8: 65535 * x / (9375 << DEN_SHIFT), truncated
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         w5[i]       = {x4_ff[i], 16'd0} - {16'd0, x4_ff[i]};
         y5_in[i]    = 30'(w5[i] >> DEN_SHIFT);
         prod6_in[i] = 61'(y5_ff[i]) * 61'(RECIP);
         q7_in[i]    = 17'(prod6_ff[i] >> RECIP_SHIFT);
         t7_in[i]    = 30'(q7_in[i]) * 30'(DEN_ODD);
         r8[i]       = y7_ff[i] - t7_ff[i];
         // quotient estimate is low by at most one
         q8[i]       = 16'(q7_ff[i] + 17'(r8[i] >= 30'(DEN_ODD)));
      end
   end

   always_comb begin
      case (sect7_ff)
         SECT_RY: rsp_in = '{red: q8[LANE_V], green: q8[LANE_K], blue: q8[LANE_M]};
         SECT_YG: rsp_in = '{red: q8[LANE_N], green: q8[LANE_V], blue: q8[LANE_M]};
         SECT_GC: rsp_in = '{red: q8[LANE_M], green: q8[LANE_V], blue: q8[LANE_K]};
         SECT_CB: rsp_in = '{red: q8[LANE_M], green: q8[LANE_N], blue: q8[LANE_V]};
         SECT_BM: rsp_in = '{red: q8[LANE_K], green: q8[LANE_M], blue: q8[LANE_V]};
         default: rsp_in = '{red: q8[LANE_V], green: q8[LANE_M], blue: q8[LANE_N]};
      endcase
   end

   // hold every stage while the output waits
   always_ff @(posedge clock) begin
      if (adv) begin
         sect1_ff  <= sect1_in;
         frac1_ff  <= frac1_in;
         sat1_ff   <= sat_in;
         light1_ff <= light_in;
         lsq1_ff   <= lsq1_in;
         low1_ff   <= low1_in;

         vn2_ff    <= vn2_in;
         mn2_ff    <= mn2_in;
         sect2_ff  <= sect1_ff;
         frac2_ff  <= frac1_ff;

         p3_ff     <= p3_in;
         xv3_ff    <= xv3_in;
         xm3_ff    <= xm3_in;
         sect3_ff  <= sect2_ff;

         x4_ff     <= x4_in;
         sect4_ff  <= sect3_ff;

         y5_ff     <= y5_in;
         sect5_ff  <= sect4_ff;

         prod6_ff  <= prod6_in;
         y6_ff     <= y5_ff;
         sect6_ff  <= sect5_ff;

         q7_ff     <= q7_in;
         t7_ff     <= t7_in;
         y7_ff     <= y6_ff;
         sect7_ff  <= sect6_ff;

         rsp_ff    <= rsp_in;
      end
   end

   `HSL_ASSERT_SAME(a_m_below_v, valid_ff[2], xm3_ff <= xv3_ff,
                    "M numerator exceeds v numerator")
   `HSL_ASSERT_SAME(a_k_between, valid_ff[3],
                    (x4_ff[LANE_K] >= x4_ff[LANE_M]) && (x4_ff[LANE_K] <= x4_ff[LANE_V]),
                    "K numerator outside M..v")
   `HSL_ASSERT_SAME(a_div_remainder, valid_ff[6], r8[LANE_K] < 30'(2 * DEN_ODD),
                    "reciprocal quotient off by more than one")
   `HSL_ASSERT_NEXT(a_stall_holds, valid_ff[STAGES-1] && !rsp_ready, $stable(valid_ff),
                    "pipeline moved during output stall")

endmodule

`default_nettype wire
